[rtl/core/idt_pkg.sv]
// types, constants and coefficient table of the infrared distance linearisation
`default_nettype none

package idt_pkg;

   localparam int CHAN_W               = 3;
   localparam int SAMPLE_W             = 12;
   localparam int DIST_W               = 15;
   localparam int FRAC_BITS            = 8;
   localparam int GAIN_W               = 20;
   localparam int OFFSET_W             = 17;
   localparam int GAIN_FACTOR          = 10;
   localparam int TABLE_SIZE           = 5;
   localparam int NUM_W                = 23;
   localparam int DEN_W                = SAMPLE_W + FRAC_BITS;
   localparam int DEFAULT_ADC_BITS     = 12;
   localparam int DEFAULT_NUM_CHANNELS = 5;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_CHANNEL,
      ST_NOT_ABOVE,
      ST_SATURATED
   } idt_status_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [SAMPLE_W-1:0] sample;
   } idt_req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      idt_status_type    status;
   } idt_rsp_type;

   typedef struct packed {
      idt_status_type     status;
      logic [NUM_W-1:0]   num;
      logic [DEN_W-1:0]   den;
      logic [DEN_W-1:0]   rem;
      logic [NUM_W-1:0]   quo;
   } idt_div_type;

   // gain in Q.8
   function automatic logic [GAIN_W-1:0] idt_gain(input logic [CHAN_W-1:0] chan);
      logic [GAIN_W-1:0] g;
      unique case (chan)
         3'd0:    g = 20'd409258;
         3'd1:    g = 20'd493339;
         3'd2:    g = 20'd615344;
         3'd3:    g = 20'd626628;
         3'd4:    g = 20'd533387;
         default: g = '0;
      endcase
      return g;
   endfunction

   // offset in Q.8
   function automatic logic [OFFSET_W-1:0] idt_offset(input logic [CHAN_W-1:0] chan);
      logic [OFFSET_W-1:0] o;
      unique case (chan)
         3'd0:    o = 17'd69061;
         3'd1:    o = 17'd58605;
         3'd2:    o = 17'd46980;
         3'd3:    o = 17'd47685;
         3'd4:    o = 17'd52742;
         default: o = '0;
      endcase
      return o;
   endfunction

endpackage

`default_nettype wire

[rtl/core/idt_lookup.sv]
// first pipeline stage: coefficient lookup, range checks, numerator and divisor
`default_nettype none

module idt_lookup #(
   parameter int ADC_BITS     = idt_pkg::DEFAULT_ADC_BITS,
   parameter int NUM_CHANNELS = idt_pkg::DEFAULT_NUM_CHANNELS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire idt_pkg::idt_req_type in_data,
   output logic                     in_stall,
   output logic                     out_valid,
   output idt_pkg::idt_div_type     out_data,
   input  wire logic                out_stall
);
   import idt_pkg::*;

   localparam int KEEP_BITS = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << KEEP_BITS) - 1);

   logic              valid_ff;
   idt_div_type       data_ff;
   idt_div_type       data_in;
   logic              load;
   logic              chan_ok;
   logic [DEN_W-1:0]  s_q8;
   logic [DEN_W-1:0]  off;
   logic [GAIN_W-1:0] gain;

   assign load     = !(valid_ff && out_stall);
   assign in_stall = !load;

   always_comb begin
      chan_ok = (int'(in_data.channel) < NUM_CHANNELS) &&
                (int'(in_data.channel) < TABLE_SIZE);
      gain    = idt_gain(in_data.channel);
      off     = DEN_W'(idt_offset(in_data.channel));
      s_q8    = {in_data.sample & SAMPLE_MASK, {FRAC_BITS{1'b0}}};

      data_in.num = NUM_W'(gain * GAIN_FACTOR);
      data_in.den = s_q8 - off;
      data_in.rem = '0;
      data_in.quo = '0;
      priority if (!chan_ok) begin
         data_in.status = ST_BAD_CHANNEL;
      end else if (s_q8 <= off) begin
         data_in.status = ST_NOT_ABOVE;
      end else begin
         data_in.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[rtl/core/idt_div_step.sv]
// one restoring division stage: one quotient bit per stage
`default_nettype none

module idt_div_step (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire idt_pkg::idt_div_type in_data,
   output logic                      in_stall,
   output logic                      out_valid,
   output idt_pkg::idt_div_type      out_data,
   input  wire logic                 out_stall
);
   import idt_pkg::*;

   logic             valid_ff;
   idt_div_type      data_ff;
   idt_div_type      data_in;
   logic             load;
   logic [DEN_W:0]   rem_sh;
   logic             fits;

   assign load     = !(valid_ff && out_stall);
   assign in_stall = !load;

   always_comb begin
      rem_sh = {in_data.rem, in_data.num[NUM_W-1]};
      fits   = rem_sh >= {1'b0, in_data.den};

      data_in        = in_data;
      data_in.num    = {in_data.num[NUM_W-2:0], 1'b0};
      data_in.quo    = {in_data.quo[NUM_W-2:0], fits};
      data_in.rem    = fits ? DEN_W'(rem_sh - {1'b0, in_data.den}) : DEN_W'(rem_sh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[rtl/core/idt_result.sv]
// output stage: saturation, status and the result register
`default_nettype none

module idt_result (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire idt_pkg::idt_div_type in_data,
   output logic                      in_stall,
   output logic                      out_valid,
   output idt_pkg::idt_rsp_type      out_data,
   input  wire logic                 out_stall
);
   import idt_pkg::*;

   logic        valid_ff;
   idt_rsp_type data_ff;
   idt_rsp_type data_in;
   logic        load;

   assign load     = !(valid_ff && out_stall);
   assign in_stall = !load;

   always_comb begin
      unique case (in_data.status)
         ST_OK: begin
            if (in_data.quo[NUM_W-1:DIST_W] != '0) begin
               data_in.distance = DIST_MAX;
               data_in.status   = ST_SATURATED;
            end else begin
               data_in.distance = in_data.quo[DIST_W-1:0];
               data_in.status   = ST_OK;
            end
         end
         default: begin
            data_in.distance = '0;
            data_in.status   = in_data.status;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[rtl/core/ir_adc_to_distance.sv]
// infrared sensor reading to distance: floor(10*gain / (sample - offset)), pipelined
// pipeline: lookup stage, one stage per quotient bit of the 23-bit restoring divider,
// output register
// throughput: one transaction per cycle; each stage holds only while the one after it holds
// reset: synchronous, active high; clears all stage valid bits, data registers keep their value
// the coefficient table is constant logic, so no warm-up after reset
`default_nettype none

module ir_adc_to_distance #(
   parameter int ADC_BITS     = idt_pkg::DEFAULT_ADC_BITS,
   parameter int NUM_CHANNELS = idt_pkg::DEFAULT_NUM_CHANNELS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire idt_pkg::idt_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output idt_pkg::idt_rsp_type      rsp_data
);
   import idt_pkg::*;

   logic        stage_valid [0:NUM_W];
   idt_div_type stage_data  [0:NUM_W];
   logic        stage_stall [0:NUM_W];

   idt_lookup #(
      .ADC_BITS     (ADC_BITS),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_lookup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_stall  (req_stall),
      .out_valid (stage_valid[0]),
      .out_data  (stage_data[0]),
      .out_stall (stage_stall[0])
   );

   for (genvar k = 1; k <= NUM_W; k++) begin : g_div
      idt_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k-1]),
         .in_data   (stage_data[k-1]),
         .in_stall  (stage_stall[k-1]),
         .out_valid (stage_valid[k]),
         .out_data  (stage_data[k]),
         .out_stall (stage_stall[k])
      );
   end

   idt_result u_result (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[NUM_W]),
      .in_data   (stage_data[NUM_W]),
      .in_stall  (stage_stall[NUM_W]),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

`ifndef ASSERT_OFF
   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_bad_channel_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_BAD_CHANNEL) |-> (rsp_data.distance == '0))
      else $error("bad channel result with nonzero distance");

   a_not_above_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_NOT_ABOVE) |-> (rsp_data.distance == '0))
      else $error("offset case with nonzero distance");

   a_saturated_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_SATURATED) |-> (rsp_data.distance == DIST_MAX))
      else $error("saturated result below full scale");
`endif

endmodule

`default_nettype wire
